### rtl/core/tga_pkg.sv
// Shared constants for the TGA header parser and pixel unpacker.
`timescale 1ns / 1ps
`default_nettype none

package tga_pkg;

  // Result kinds carried on the output channel
  typedef enum logic [1:0] {
    KIND_HEADER     = 2'd0,
    KIND_PIXEL      = 2'd1,
    KIND_WRONG_TYPE = 2'd2,
    KIND_BAD_DEPTH  = 2'd3
  } result_kind_t;

  // Header byte positions of interest
  localparam logic [4:0] HDR_ID_LEN     = 5'd0;
  localparam logic [4:0] HDR_MAP_TYPE   = 5'd1;
  localparam logic [4:0] HDR_TYPE_CODE  = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO   = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI   = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO  = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI  = 5'd15;
  localparam logic [4:0] HDR_DEPTH      = 5'd16;
  localparam logic [4:0] HDR_DESCRIPTOR = 5'd17;

  // Accepted image format: uncompressed true colour, no colour map
  localparam logic [7:0] TYPE_TRUECOLOUR = 8'd2;
  localparam logic [7:0] MAP_NONE        = 8'd0;
  localparam logic [7:0] DEPTH_24        = 8'd24;
  localparam logic [7:0] DEPTH_32        = 8'd32;
  localparam logic [7:0] ALPHA_OPAQUE    = 8'hFF;

  // Byte positions within one stored pixel (B, G, R, A)
  localparam logic [1:0] PIX_BLUE  = 2'd0;
  localparam logic [1:0] PIX_GREEN = 2'd1;
  localparam logic [1:0] PIX_RED   = 2'd2;
  localparam logic [1:0] PIX_ALPHA = 2'd3;

endpackage

`default_nettype wire

### rtl/core/tga_header_parse_pixel_unpack_top.sv
// TGA header parser and pixel unpacker: byte stream in, header/pixel/error results out.
// A result is captured in the output register as its byte transfers.
// Throughput: one byte per cycle; a byte is taken every cycle unless a result waits
//   on the output register while the output side stalls.
// Header result comes with the descriptor byte, pixel results with the last byte of each pixel.
// Reset (rst, synchronous, active high) returns the parser to idle, waiting for a start byte.
`timescale 1ns / 1ps
`default_nettype none

module tga_header_parse_pixel_unpack_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // Byte input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        start_of_file,
  // Result output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       result_kind,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  output logic [7:0]       alpha,
  output logic [15:0]      image_width,
  output logic [15:0]      image_height,
  output logic             has_alpha,
  output logic             last
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_IDSKIP,
    PH_PIXELS,
    PH_HALT
  } phase_t;

  // Parser state
  phase_t      phase;
  logic [4:0]  header_index;
  logic [7:0]  id_skip_left;
  logic [7:0]  map_type_seen;
  logic [7:0]  type_code_seen;
  logic [7:0]  depth_seen;
  logic [15:0] width_seen;
  logic [15:0] height_seen;
  logic [31:0] pixels_left;
  logic [1:0]  byte_in_pixel;
  logic [7:0]  held_blue;
  logic [7:0]  held_green;
  logic [7:0]  held_red;

  phase_t      phase_next;
  logic [4:0]  header_index_next;
  logic [7:0]  id_skip_left_next;
  logic [7:0]  map_type_seen_next;
  logic [7:0]  type_code_seen_next;
  logic [7:0]  depth_seen_next;
  logic [15:0] width_seen_next;
  logic [15:0] height_seen_next;
  logic [31:0] pixels_left_next;
  logic [1:0]  byte_in_pixel_next;
  logic [7:0]  held_blue_next;
  logic [7:0]  held_green_next;
  logic [7:0]  held_red_next;

  // Result produced by the current byte
  logic                  res_valid;
  tga_pkg::result_kind_t res_kind;
  logic [7:0]            res_red;
  logic [7:0]            res_green;
  logic [7:0]            res_blue;
  logic [7:0]            res_alpha;
  logic [15:0]           res_width;
  logic [15:0]           res_height;
  logic                  res_has_alpha;
  logic                  res_last;

  // Working values
  phase_t      ph_eff;
  logic [4:0]  idx_eff;
  logic [1:0]  bip_eff;
  logic        in_fire;
  logic        four;
  logic        type_ok;
  logic        depth_ok;
  logic [31:0] pixel_count;
  logic [31:0] pixels_dec;

  // Input side holds only while a result waits and the output is stalled
  assign in_stall = out_valid & out_stall;
  assign in_fire  = in_valid & ~in_stall;

  // A start byte restarts the header parse on this very byte
  assign ph_eff  = start_of_file ? PH_HEADER : phase;
  assign idx_eff = start_of_file ? 5'd0 : header_index;
  assign bip_eff = start_of_file ? 2'd0 : byte_in_pixel;

  assign four        = (depth_seen == tga_pkg::DEPTH_32);
  assign type_ok     = (type_code_seen == tga_pkg::TYPE_TRUECOLOUR) &&
                       (map_type_seen == tga_pkg::MAP_NONE);
  assign depth_ok    = (depth_seen == tga_pkg::DEPTH_24) || four;
  assign pixel_count = {16'd0, width_seen} * {16'd0, height_seen};
  assign pixels_dec  = pixels_left - 32'd1;

  // Next-state and result logic for one byte
  always_comb begin
    phase_next          = ph_eff;
    header_index_next   = idx_eff;
    id_skip_left_next   = id_skip_left;
    map_type_seen_next  = map_type_seen;
    type_code_seen_next = type_code_seen;
    depth_seen_next     = depth_seen;
    width_seen_next     = width_seen;
    height_seen_next    = height_seen;
    pixels_left_next    = pixels_left;
    byte_in_pixel_next  = bip_eff;
    held_blue_next      = held_blue;
    held_green_next     = held_green;
    held_red_next       = held_red;

    res_valid     = 1'b0;
    res_kind      = tga_pkg::KIND_HEADER;
    res_red       = 8'd0;
    res_green     = 8'd0;
    res_blue      = 8'd0;
    res_alpha     = 8'd0;
    res_width     = 16'd0;
    res_height    = 16'd0;
    res_has_alpha = 1'b0;
    res_last      = 1'b0;

    case (ph_eff)
      PH_HEADER: begin
        header_index_next = idx_eff + 5'd1;
        case (idx_eff)
          tga_pkg::HDR_ID_LEN:    id_skip_left_next   = data_byte;
          tga_pkg::HDR_MAP_TYPE:  map_type_seen_next  = data_byte;
          tga_pkg::HDR_TYPE_CODE: type_code_seen_next = data_byte;
          tga_pkg::HDR_WIDTH_LO:  width_seen_next     = {width_seen[15:8], data_byte};
          tga_pkg::HDR_WIDTH_HI:  width_seen_next     = {data_byte, width_seen[7:0]};
          tga_pkg::HDR_HEIGHT_LO: height_seen_next    = {height_seen[15:8], data_byte};
          tga_pkg::HDR_HEIGHT_HI: height_seen_next    = {data_byte, height_seen[7:0]};
          tga_pkg::HDR_DEPTH:     depth_seen_next     = data_byte;
          tga_pkg::HDR_DESCRIPTOR: begin
            res_valid = 1'b1;
            if (!type_ok) begin
              phase_next = PH_HALT;
              res_kind   = tga_pkg::KIND_WRONG_TYPE;
            end else if (!depth_ok) begin
              phase_next = PH_HALT;
              res_kind   = tga_pkg::KIND_BAD_DEPTH;
            end else begin
              pixels_left_next   = pixel_count;
              byte_in_pixel_next = tga_pkg::PIX_BLUE;
              res_kind           = tga_pkg::KIND_HEADER;
              res_width          = width_seen;
              res_height         = height_seen;
              res_has_alpha      = four;
              res_last           = (pixel_count == 32'd0);
              if (pixel_count == 32'd0) begin
                phase_next = PH_HALT;
              end else if (id_skip_left != 8'd0) begin
                phase_next = PH_IDSKIP;
              end else begin
                phase_next = PH_PIXELS;
              end
            end
          end
          default: ;  // colour map info and origin are not kept
        endcase
      end

      PH_IDSKIP: begin
        id_skip_left_next = id_skip_left - 8'd1;
        if (id_skip_left == 8'd1) begin
          phase_next = PH_PIXELS;
        end
      end

      PH_PIXELS: begin
        case (bip_eff)
          tga_pkg::PIX_BLUE: begin
            held_blue_next     = data_byte;
            byte_in_pixel_next = tga_pkg::PIX_GREEN;
          end
          tga_pkg::PIX_GREEN: begin
            held_green_next    = data_byte;
            byte_in_pixel_next = tga_pkg::PIX_RED;
          end
          tga_pkg::PIX_RED: begin
            held_red_next = data_byte;
            if (four) begin
              byte_in_pixel_next = tga_pkg::PIX_ALPHA;
            end else begin
              res_valid = 1'b1;
              res_red   = data_byte;
              res_alpha = tga_pkg::ALPHA_OPAQUE;
            end
          end
          default: begin
            res_valid = 1'b1;
            res_red   = held_red;
            res_alpha = data_byte;
          end
        endcase
        // Pixel complete: emit it and count it off
        if (res_valid) begin
          byte_in_pixel_next = tga_pkg::PIX_BLUE;
          pixels_left_next   = pixels_dec;
          res_kind           = tga_pkg::KIND_PIXEL;
          res_green          = held_green;
          res_blue           = held_blue;
          res_has_alpha      = four;
          res_last           = (pixels_dec == 32'd0);
          if (pixels_dec == 32'd0) begin
            phase_next = PH_HALT;
          end
        end
      end

      default: ;  // idle or halted: bytes are dropped
    endcase
  end

  // Parser state registers, advanced on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      header_index   <= 5'd0;
      id_skip_left   <= 8'd0;
      map_type_seen  <= 8'd0;
      type_code_seen <= 8'd0;
      depth_seen     <= 8'd0;
      width_seen     <= 16'd0;
      height_seen    <= 16'd0;
      pixels_left    <= 32'd0;
      byte_in_pixel  <= 2'd0;
      held_blue      <= 8'd0;
      held_green     <= 8'd0;
      held_red       <= 8'd0;
    end else if (in_fire) begin
      phase          <= phase_next;
      header_index   <= header_index_next;
      id_skip_left   <= id_skip_left_next;
      map_type_seen  <= map_type_seen_next;
      type_code_seen <= type_code_seen_next;
      depth_seen     <= depth_seen_next;
      width_seen     <= width_seen_next;
      height_seen    <= height_seen_next;
      pixels_left    <= pixels_left_next;
      byte_in_pixel  <= byte_in_pixel_next;
      held_blue      <= held_blue_next;
      held_green     <= held_green_next;
      held_red       <= held_red_next;
    end
  end

  // Output register: loads whenever it is empty or its result is being taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid & res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      result_kind  <= res_kind;
      red          <= res_red;
      green        <= res_green;
      blue         <= res_blue;
      alpha        <= res_alpha;
      image_width  <= res_width;
      image_height <= res_height;
      has_alpha    <= res_has_alpha;
      last         <= res_last;
    end
  end

`ifndef SYNTHESIS
  // An error result always leaves the parser halted
  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    (in_fire && res_valid &&
     (res_kind == tga_pkg::KIND_WRONG_TYPE || res_kind == tga_pkg::KIND_BAD_DEPTH))
    |=> (phase == PH_HALT))
    else $error("error result did not halt the parser");

  // The final result of an image leaves the parser halted
  a_last_halts: assert property (@(posedge clk) disable iff (rst)
    (in_fire && res_valid && res_last) |=> (phase == PH_HALT))
    else $error("last result did not halt the parser");

  // Pixel phase always has pixels still to come
  a_pixels_pending: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PIXELS) |-> (pixels_left != 32'd0))
    else $error("pixel phase with no pixels left");

  // Input holds only behind a waiting result
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  // Pixel results carry no header dimensions
  a_pixel_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == tga_pkg::KIND_PIXEL)
    |-> (image_width == 16'd0 && image_height == 16'd0))
    else $error("pixel result carries header dimensions");
`endif

endmodule

`default_nettype wire
